// File: hw/rtl/software_timer_slot_table_macros.svh
// ----------------------------------------------------------------------------
// Timer slot table assertion macros
// Shared concurrent assertion shorthands for the slot table checkers.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define STST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define STST_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `STST_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: hw/rtl/stst_pkg.sv
// ----------------------------------------------------------------------------
// Timer slot table package
// Sizes, codes and shared types of the timer slot table.
// ----------------------------------------------------------------------------
package stst_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TOKEN_W     = 16;
  localparam int PERIOD_W    = 32;
  localparam int INTERVAL_W  = 32;
  localparam int TIME_W      = 64;
  localparam int SLOT_W      = 4;
  localparam int KIND_W      = 2;
  localparam int OPC_W       = 2;
  localparam int MODE_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MUL_CNT_W   = $clog2(INTERVAL_W);

  // input opcodes
  localparam logic [OPC_W-1:0] OPC_TICK  = 2'd0;
  localparam logic [OPC_W-1:0] OPC_REG   = 2'd1;
  localparam logic [OPC_W-1:0] OPC_UNREG = 2'd2;

  // trigger modes
  localparam logic [MODE_W-1:0] MODE_EVERY    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_REG,
    CMD_UNREG
  } cmd_op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_REG,
    BK_UNREG,
    BK_FAIL,
    BK_TICK,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [TOKEN_W-1:0]    cb;
    logic [TOKEN_W-1:0]    arg;
    logic [MODE_W-1:0]     mode;
    logic [PERIOD_W-1:0]   period;
    logic                  ctx;
    logic                  no_cb;
  } cmd_t;

  typedef struct packed {
    logic [TOKEN_W-1:0]    cb;
    logic [TOKEN_W-1:0]    arg;
    logic [MODE_W-1:0]     mode;
    logic [PERIOD_W-1:0]   period;
    logic [TIME_W-1:0]     last_fire;
  } slot_ent_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic                  ok;
    logic [SLOT_W-1:0]     slot;
    logic [TOKEN_W-1:0]    cb;
    logic [TOKEN_W-1:0]    arg;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic busy;   // running or product valid
    logic done;   // product valid this cycle
  } mul_stat_t;

endpackage

// File: hw/rtl/stst_ifs.sv
// ----------------------------------------------------------------------------
// Timer slot table channels
// Valid/ready channel interfaces for input items, results and configuration.
// ----------------------------------------------------------------------------
interface stst_in_if;
  import stst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPC_W-1:0]     opcode;
  logic [TOKEN_W-1:0]   callback_id;
  logic [TOKEN_W-1:0]   arg_id;
  logic [MODE_W-1:0]    trigger_mode;
  logic [PERIOD_W-1:0]  period_us;
  logic                 has_context;

  modport source (output valid, opcode, callback_id, arg_id, trigger_mode,
                  period_us, has_context, input ready);
  modport sink   (input valid, opcode, callback_id, arg_id, trigger_mode,
                  period_us, has_context, output ready);
endinterface

interface stst_out_if;
  import stst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic                 ok;
  logic [SLOT_W-1:0]    slot;
  logic [TOKEN_W-1:0]   fire_callback_id;
  logic [TOKEN_W-1:0]   fire_arg_id;
  logic                 last;

  modport source (output valid, kind, ok, slot, fire_callback_id, fire_arg_id,
                  last, input ready);
  modport sink   (input valid, kind, ok, slot, fire_callback_id, fire_arg_id,
                  last, output ready);
endinterface

interface stst_cfg_if;
  import stst_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [INTERVAL_W-1:0]  tick_interval_us;

  modport source (output valid, tick_interval_us, input ready);
  modport sink   (input valid, tick_interval_us, output ready);
endinterface

// File: hw/rtl/stst_front.sv
// ----------------------------------------------------------------------------
// Timer slot table front end
// Accepts input items, decodes them into commands, drops unused opcodes.
// ----------------------------------------------------------------------------
module stst_front (
  stst_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output stst_pkg::cmd_t push_cmd
);
  import stst_pkg::*;

  logic known;

  assign in_ch.ready = !q_full;

  always_comb begin
    known           = 1'b1;
    push_cmd.op     = CMD_TICK;
    push_cmd.cb     = in_ch.callback_id;
    push_cmd.arg    = in_ch.arg_id;
    push_cmd.mode   = in_ch.trigger_mode;
    push_cmd.period = in_ch.period_us;
    push_cmd.ctx    = in_ch.has_context;
    push_cmd.no_cb  = (in_ch.callback_id == '0);
    case (in_ch.opcode)
      OPC_TICK:  push_cmd.op = CMD_TICK;
      OPC_REG:   push_cmd.op = CMD_REG;
      OPC_UNREG: push_cmd.op = CMD_UNREG;
      default:   known = 1'b0;   // reserved opcode: taken and dropped
    endcase
  end

  assign push = in_ch.valid && !q_full && known;

endmodule

// File: hw/rtl/stst_queue.sv
// ----------------------------------------------------------------------------
// Timer slot table command queue
// Short FIFO of decoded commands between front end and slot engine.
// ----------------------------------------------------------------------------
module stst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  stst_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output stst_pkg::cmd_t head
);
  import stst_pkg::*;

  cmd_t              store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = store_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push   ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/stst_mul.sv
// ----------------------------------------------------------------------------
// Timer slot table time multiplier
// Shift-add product of tick count and tick interval, modulo 2^64.
// ----------------------------------------------------------------------------
module stst_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [stst_pkg::TIME_W-1:0]     a,
  input  logic [stst_pkg::INTERVAL_W-1:0] b,
  output stst_pkg::mul_stat_t             stat,
  output logic [stst_pkg::TIME_W-1:0]     prod
);
  import stst_pkg::*;

  logic [TIME_W-1:0]     acc_r, acc_nxt;
  logic [TIME_W-1:0]     a_r, a_nxt;
  logic [INTERVAL_W-1:0] b_r, b_nxt;
  logic [MUL_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one multiplier bit per cycle
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(INTERVAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign stat.busy = busy_r || done_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

// File: hw/rtl/stst_back.sv
// ----------------------------------------------------------------------------
// Timer slot table engine
// Executes commands against the slot memory and drives the result register.
// ----------------------------------------------------------------------------
module stst_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  stst_pkg::cmd_t                  head,
  output logic                            pop,
  input  logic                            cfg_wr,
  input  logic [stst_pkg::INTERVAL_W-1:0] cfg_data,
  output logic                            mul_start,
  output logic [stst_pkg::TIME_W-1:0]     mul_a,
  input  stst_pkg::mul_stat_t             mul_stat,
  input  logic [stst_pkg::TIME_W-1:0]     mul_prod,
  output logic                            out_valid,
  input  logic                            out_ready,
  output stst_pkg::res_t                  out_res
);
  import stst_pkg::*;

  bk_state_t             state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [TIME_W-1:0]     tick_total_r, tick_total_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [INTERVAL_W-1:0] interval_r;
  logic                  out_vld_r, out_vld_nxt;
  res_t                  out_res_r, out_res_nxt;

  slot_ent_t             slot_mem [SLOT_COUNT];
  slot_ent_t             rd_ent_r;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  slot_ent_t             wr_ent;

  logic                  emit;
  res_t                  res;
  logic [IDX_W-1:0]      free_idx;
  logic                  full;
  logic                  cur_valid;
  logic                  match;
  logic                  due;
  logic                  fire;
  logic                  space;
  logic                  last_idx;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(SLOT_COUNT - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign full      = &valid_r;
  assign cur_valid = valid_r[idx_r];
  assign match     = cur_valid && (rd_ent_r.cb == cmd_r.cb) && (rd_ent_r.arg == cmd_r.arg);
  assign due       = (now_r - rd_ent_r.last_fire) >= TIME_W'(rd_ent_r.period);
  assign fire      = cur_valid && ((rd_ent_r.mode == MODE_EVERY) ||
                     ((rd_ent_r.mode inside {MODE_PERIODIC, MODE_ONESHOT}) && due));
  assign space     = !out_vld_r || out_ready;
  assign last_idx  = (idx_r == IDX_W'(SLOT_COUNT - 1));
  assign pop       = (state_r == BK_IDLE) && q_valid && !mul_stat.busy;

  assign mul_start = cfg_wr;
  assign mul_a     = tick_total_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop) begin
          case (head.op)
            CMD_REG:   state_nxt = BK_REG;
            CMD_UNREG: state_nxt = head.no_cb ? BK_FAIL : BK_UNREG;
            CMD_TICK:  state_nxt = head.ctx ? BK_TICK : BK_DONE;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_REG: begin
        if (space) state_nxt = BK_IDLE;
      end
      BK_UNREG: begin
        if (match) begin
          if (space) state_nxt = BK_IDLE;
        end else if (last_idx) begin
          state_nxt = BK_FAIL;
        end
      end
      BK_FAIL: begin
        if (space) state_nxt = BK_IDLE;
      end
      BK_TICK: begin
        if ((!fire || space) && last_idx) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (space) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    valid_nxt      = valid_r;
    tick_total_nxt = tick_total_r;
    now_nxt        = mul_stat.done ? mul_prod : now_r;
    wr_en          = 1'b0;
    wr_idx         = idx_r;
    wr_ent         = rd_ent_r;
    emit           = 1'b0;
    res.kind       = KIND_STATUS;
    res.ok         = 1'b0;
    res.slot       = '0;
    res.cb         = cmd_r.cb;
    res.arg        = cmd_r.arg;
    res.last       = 1'b1;
    case (state_r)
      BK_IDLE: begin
        idx_nxt = '0;
        if (pop) begin
          cmd_nxt = head;
          if (head.op == CMD_TICK) begin
            tick_total_nxt = tick_total_r + 1'b1;
            now_nxt        = now_r + TIME_W'(interval_r);
          end
        end
      end
      BK_REG: begin
        if (space) begin
          emit = 1'b1;
          if (!full && !cmd_r.no_cb) begin
            wr_en            = 1'b1;
            wr_idx           = free_idx;
            wr_ent.cb        = cmd_r.cb;
            wr_ent.arg       = cmd_r.arg;
            wr_ent.mode      = cmd_r.mode;
            wr_ent.period    = (cmd_r.mode == MODE_EVERY) ? interval_r : cmd_r.period;
            wr_ent.last_fire = now_r;
            valid_nxt[free_idx] = 1'b1;
            res.ok           = 1'b1;
            res.slot         = SLOT_W'(free_idx);
          end
        end
      end
      BK_UNREG: begin
        if (match) begin
          if (space) begin
            emit             = 1'b1;
            res.ok           = 1'b1;
            res.slot         = SLOT_W'(idx_r);
            valid_nxt[idx_r] = 1'b0;
          end
        end else begin
          idx_nxt = idx_inc(idx_r);
        end
      end
      BK_FAIL: begin
        emit = space;
      end
      BK_TICK: begin
        if (fire) begin
          if (space) begin
            emit     = 1'b1;
            res.kind = KIND_FIRE;
            res.ok   = 1'b1;
            res.slot = SLOT_W'(idx_r);
            res.cb   = rd_ent_r.cb;
            res.arg  = rd_ent_r.arg;
            res.last = 1'b0;
            if (rd_ent_r.mode == MODE_PERIODIC) begin
              wr_en            = 1'b1;
              wr_ent.last_fire = now_r;
            end else if (rd_ent_r.mode == MODE_ONESHOT) begin
              valid_nxt[idx_r] = 1'b0;
            end
            idx_nxt = idx_inc(idx_r);
          end
        end else begin
          idx_nxt = idx_inc(idx_r);
        end
      end
      BK_DONE: begin
        emit     = space;
        res.kind = KIND_DONE;
        res.ok   = 1'b1;
        res.cb   = '0;
        res.arg  = '0;
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
    out_vld_nxt = emit || (out_vld_r && !out_ready);
    out_res_nxt = emit ? res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      idx_r        <= '0;
      valid_r      <= '0;
      tick_total_r <= '0;
      now_r        <= '0;
      interval_r   <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      valid_r      <= valid_nxt;
      tick_total_r <= tick_total_nxt;
      now_r        <= now_nxt;
      out_vld_r    <= out_vld_nxt;
      if (cfg_wr) begin
        interval_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    out_res_r <= out_res_nxt;
  end

  // slot memory: one write port, read one slot ahead of the walk index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_idx] <= wr_ent;
    end
    rd_ent_r <= slot_mem[idx_nxt];
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

endmodule

// File: hw/rtl/software_timer_slot_table.sv
// ----------------------------------------------------------------------------
// Software timer slot table
// Timer slot table with register, unregister and tick commands; ticks with
// context fire due slots in slot order, and every tick ends with a done item.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  in_ch   | in  | valid/ready | opcode, callback_id, arg_id, trigger_mode,
//          |     |             | period_us, has_context
//  out_ch  | out | valid/ready | kind, ok, slot, fire_callback_id, fire_arg_id,
//          |     |             | last
//  cfg_ch  | in  | valid/ready | tick_interval_us (always ready)
//
//  An item is registered in the command queue, then the engine takes it.
//  Unregister walks the slots for a match, one slot memory read per cycle.
//  Tick with context: walk of all slots, one per cycle unless a firing slot
//  waits on a stalled result register, then done.
//  A configuration write starts a shift-add recompute of the current
//  time (tick count times interval); queued items wait for it.
//  Reset clears the valid bits, counters and interval at once; slot memory
//  contents are only read behind a valid bit, so no clearing pass.
//  A stalled result register holds the engine; the queue keeps taking items
//  until it is full.
//
module software_timer_slot_table (
  input  logic      clk,
  input  logic      rst_n,
  stst_in_if.sink   in_ch,
  stst_out_if.source out_ch,
  stst_cfg_if.sink  cfg_ch
);
  import stst_pkg::*;

  logic              push;
  cmd_t              push_cmd;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  cmd_t              head;
  logic              cfg_wr;
  logic              mul_start;
  logic [TIME_W-1:0] mul_a;
  mul_stat_t         mul_stat;
  logic [TIME_W-1:0] mul_prod;
  res_t              out_res;

  // configuration is always taken; the engine restarts the time product
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  // front end: decode and enqueue
  stst_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples the front end from the slot walk
  stst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  // time = tick count * interval after an interval change
  stst_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (cfg_ch.tick_interval_us),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  // slot engine with result register
  stst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .cfg_wr    (cfg_wr),
    .cfg_data  (cfg_ch.tick_interval_us),
    .mul_start (mul_start),
    .mul_a     (mul_a),
    .mul_stat  (mul_stat),
    .mul_prod  (mul_prod),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind             = out_res.kind;
  assign out_ch.ok               = out_res.ok;
  assign out_ch.slot             = out_res.slot;
  assign out_ch.fire_callback_id = out_res.cb;
  assign out_ch.fire_arg_id      = out_res.arg;
  assign out_ch.last             = out_res.last;

endmodule

// File: hw/rtl/stst_checker.sv
// ----------------------------------------------------------------------------
// Timer slot table checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "software_timer_slot_table_macros.svh"

module stst_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stst_pkg::KIND_W-1:0]  out_kind,
  input logic                         out_ok,
  input logic [stst_pkg::SLOT_W-1:0]  out_slot,
  input logic [stst_pkg::TOKEN_W-1:0] out_cb,
  input logic [stst_pkg::TOKEN_W-1:0] out_arg,
  input logic                         out_last
);
  import stst_pkg::*;

  `STST_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_kind), "result dropped while stalled")
  `STST_ASSERT_NEVER(a_fire_last, clk, rst_n, out_valid && out_kind == KIND_FIRE && (out_last || !out_ok), "fire item closes a tick or fails")
  `STST_ASSERT(a_done_shape, clk, rst_n, out_valid && out_kind == KIND_DONE |-> out_ok && out_last && out_slot == '0 && out_cb == '0 && out_arg == '0, "malformed done item")
  `STST_ASSERT(a_fail_shape, clk, rst_n, out_valid && out_kind == KIND_STATUS && !out_ok |-> out_slot == '0 && out_last, "failed status names a slot")

endmodule

bind software_timer_slot_table stst_checker u_stst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_ok    (out_ch.ok),
  .out_slot  (out_ch.slot),
  .out_cb    (out_ch.fire_callback_id),
  .out_arg   (out_ch.fire_arg_id),
  .out_last  (out_ch.last)
);
